/* design/ssmd_pkg.sv */
`default_nettype none
package ssmd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    // item operation codes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_WRITE_CHAR = 2'd1;
    localparam logic [1:0] OP_SET_BIT    = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MUX_PERIOD   = 2'd0;
    localparam logic [1:0] REG_SEG_ACT_LOW  = 2'd1;
    localparam logic [1:0] REG_DIG_ACT_LOW  = 2'd2;

    localparam logic [15:0] MUX_PERIOD_RST = 16'd1500;
    localparam logic [7:0]  CHAR_DASH      = 8'h2D;
    localparam logic [7:0]  EXTRA_OUT_MASK = 8'hF0;
    localparam logic [3:0]  DIGIT_EN_MASK  = 4'hF;

    typedef struct packed {
        logic [15:0] mux_period;
        logic        seg_active_low;
        logic        digit_active_low;
    } t_cfg;

    typedef struct packed {
        logic [7:0] digit_byte;
        logic [7:0] seg_byte;
    } t_frame;

    // segments a..g on bits 0..6, dp never lit
    function automatic logic [7:0] glyph(input logic [7:0] ch);
        logic [7:0] seg;
        unique case (ch)
            8'h30: seg = 8'h3F; // '0'
            8'h31: seg = 8'h06;
            8'h32: seg = 8'h5B;
            8'h33: seg = 8'h4F;
            8'h34: seg = 8'h66;
            8'h35: seg = 8'h6D;
            8'h36: seg = 8'h7D;
            8'h37: seg = 8'h07;
            8'h38: seg = 8'h7F;
            8'h39: seg = 8'h6F; // '9'
            8'h2D: seg = 8'h40; // '-'
            8'h5F: seg = 8'h08; // '_'
            8'h20: seg = 8'h00; // space
            8'h41, 8'h61: seg = 8'h77; // A a
            8'h62:        seg = 8'h7C; // b
            8'h43, 8'h63: seg = 8'h39; // C c
            8'h64:        seg = 8'h5E; // d
            8'h45, 8'h65: seg = 8'h79; // E e
            8'h46, 8'h66: seg = 8'h71; // F f
            8'h48, 8'h68: seg = 8'h74; // H h
            8'h49, 8'h69: seg = 8'h06; // I i
            8'h4C, 8'h6C: seg = 8'h38; // L l
            8'h4E, 8'h6E: seg = 8'h54; // N n
            8'h4F, 8'h6F: seg = 8'h3F; // O o
            8'h50, 8'h70: seg = 8'h73; // P p
            8'h55, 8'h75: seg = 8'h3E; // U u
            8'h2A:        seg = 8'h7F; // '*'
            default:      seg = 8'h00; // no glyph: blank
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

/* design/seven_segment_mux_driver.sv */
`default_nettype none
// Four-digit multiplexed seven-segment driver.
// Input channel (i_in_valid / o_in_ready) takes one item per cycle: a time
// tick, a character write into the four-character text store, or a set/clear
// of one extra-output mask bit. A tick whose refresh countdown has run out
// moves to the next digit and yields one frame; all other items yield none.
// Output channel (o_out_valid / i_out_ready) carries frames: o_digit_byte
// (one-hot digit enable in the low nibble, extra mask high nibble) and
// o_seg_byte (segments a..g, dp on bit 7).
// The input takes one item per cycle only while o_in_ready is high. A tick
// that refreshes puts its frame into the frame register, or into the skid
// while the frame register holds an untaken frame.
// A two-entry output buffer (frame register plus skid) lets the input keep
// taking items while a frame waits; o_in_ready drops only once both hold a
// frame, and returns the cycle after the receiver takes one.
// Reset (i_rst_n, synchronous, low): text "----", mask 0, digit 0, countdown 0
// (first tick refreshes), mux_period 1500, both polarities active high.
// APB registers: 0x0 mux_period, 0x4 seg_active_low, 0x8 digit_active_low.
module seven_segment_mux_driver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [1:0]  i_position,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [2:0]  i_bit_index,
    input  wire logic        i_bit_on,
    // frame output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_digit_byte,
    output logic [7:0]       o_seg_byte,
    // APB
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ssmd_pkg::*;

    t_cfg   r_cfg;
    logic   w_accept;
    logic   w_push;
    logic   w_space;
    t_frame w_frame;
    t_frame w_out_frame;
    logic   w_wr;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = w_space;

    // config registers, to be written only while idle; the user is bound to this, the block has no check of its own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mux_period       <= MUX_PERIOD_RST;
            r_cfg.seg_active_low   <= 1'b0;
            r_cfg.digit_active_low <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MUX_PERIOD:  r_cfg.mux_period       <= pwdata[15:0];
                REG_SEG_ACT_LOW: r_cfg.seg_active_low   <= pwdata[0];
                REG_DIG_ACT_LOW: r_cfg.digit_active_low <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MUX_PERIOD:  prdata = {16'd0, r_cfg.mux_period};
            REG_SEG_ACT_LOW: prdata = {31'd0, r_cfg.seg_active_low};
            REG_DIG_ACT_LOW: prdata = {31'd0, r_cfg.digit_active_low};
            default:         prdata = 32'd0;
        endcase
    end

    ssmd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_char_code (i_char_code),
        .i_bit_index (i_bit_index),
        .i_bit_on    (i_bit_on),
        .i_cfg       (r_cfg),
        .o_push      (w_push),
        .o_frame     (w_frame)
    );

    // frame register plus skid
    ssmd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frame),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_frame (w_out_frame)
    );

    assign o_digit_byte = w_out_frame.digit_byte;
    assign o_seg_byte   = w_out_frame.seg_byte;

endmodule
`default_nettype wire

/* design/ssmd_core.sv */
`default_nettype none
module ssmd_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [1:0]           i_position,
    input  wire logic [7:0]           i_char_code,
    input  wire logic [2:0]           i_bit_index,
    input  wire logic                 i_bit_on,
    input  wire ssmd_pkg::t_cfg       i_cfg,
    output logic                      o_push,
    output ssmd_pkg::t_frame          o_frame
);
    import ssmd_pkg::*;

    logic [7:0]       r_text [NUM_DIGITS];
    logic [7:0]       r_extra_mask;
    logic [IDX_W-1:0] r_digit_index;
    logic [15:0]      r_countdown;

    logic [IDX_W-1:0] n_digit_index;
    logic [15:0]      n_reload;
    logic             w_tick;
    logic             w_refresh;
    logic [7:0]       w_seg;
    logic [3:0]       w_en;

    assign w_tick        = i_accept && (i_opcode == OP_TICK);
    assign w_refresh     = w_tick && (r_countdown == 16'd0);
    assign n_digit_index = r_digit_index + IDX_W'(1);
    // zero period behaves as one
    assign n_reload      = (i_cfg.mux_period == 16'd0) ? 16'd0 : i_cfg.mux_period - 16'd1;

    always_comb begin
        w_seg = glyph(r_text[n_digit_index]);
        if (i_cfg.seg_active_low) begin
            w_seg = ~w_seg;
        end
        w_en = 4'(1) << n_digit_index;
        if (i_cfg.digit_active_low) begin
            w_en = ~w_en & DIGIT_EN_MASK;
        end
        o_frame.seg_byte   = w_seg;
        o_frame.digit_byte = {4'b0000, w_en} | (r_extra_mask & EXTRA_OUT_MASK);
    end

    assign o_push = w_refresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_text[i] <= CHAR_DASH;
            end
            r_extra_mask  <= 8'h00;
            r_digit_index <= '0;
            r_countdown   <= 16'd0;
        end else if (i_accept) begin
            unique case (i_opcode)
                OP_WRITE_CHAR: begin
                    r_text[i_position] <= i_char_code;
                end
                OP_SET_BIT: begin
                    r_extra_mask[i_bit_index] <= i_bit_on;
                end
                OP_TICK: begin
                    if (r_countdown != 16'd0) begin
                        r_countdown <= r_countdown - 16'd1;
                    end else begin
                        r_countdown   <= n_reload;
                        r_digit_index <= n_digit_index;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/ssmd_out_buf.sv */
`default_nettype none
module ssmd_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire ssmd_pkg::t_frame     i_frame,
    output logic                      o_space,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output ssmd_pkg::t_frame          o_frame
);
    import ssmd_pkg::*;

    logic   r_out_valid;
    logic   r_skid_valid;
    t_frame r_out;
    t_frame r_skid;
    logic   w_free;

    assign w_free  = !r_out_valid || i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_frame = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out <= r_skid_valid ? r_skid : i_frame;
        end else if (i_push) begin
            r_skid <= i_frame;
        end
    end

endmodule
`default_nettype wire

/* dv/seven_segment_mux_driver_checker.sv */
`timescale 1ns / 100ps
module seven_segment_mux_driver_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [1:0]  i_position,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [2:0]  i_bit_index,
    input  wire logic        i_bit_on,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_digit_byte,
    input  wire logic [7:0]  i_seg_byte,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_errors,
    output int               o_outstanding
);
    import ssmd_pkg::*;

    localparam int REPORT_LIMIT = 40;

    // shadow of the display state and registers
    logic [7:0]  text_q [NUM_DIGITS];
    logic [7:0]  mask_q;
    logic [1:0]  digit_q;
    logic [15:0] countdown_q;
    logic [15:0] period_q;
    logic        seg_low_q;
    logic        dig_low_q;

    t_frame frames_due [$];
    t_frame want;
    logic [31:0] reg_val;

    initial o_errors = 0;

    task automatic report_mismatch(input string msg);
        if (o_errors < REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
        o_errors++;
    endtask

    function automatic logic [7:0] char_to_segments(input logic [7:0] ch);
        case (ch)
            "0", "O", "o":  return 8'h3F;
            "1", "I", "i":  return 8'h06;
            "2":            return 8'h5B;
            "3":            return 8'h4F;
            "4":            return 8'h66;
            "5":            return 8'h6D;
            "6":            return 8'h7D;
            "7":            return 8'h07;
            "8", "*":       return 8'h7F;
            "9":            return 8'h6F;
            "-":            return 8'h40;
            "_":            return 8'h08;
            "A", "a":       return 8'h77;
            "b":            return 8'h7C;
            "C", "c":       return 8'h39;
            "d":            return 8'h5E;
            "E", "e":       return 8'h79;
            "F", "f":       return 8'h71;
            "H", "h":       return 8'h74;
            "L", "l":       return 8'h38;
            "N", "n":       return 8'h54;
            "P", "p":       return 8'h73;
            "U", "u":       return 8'h3E;
            default:        return 8'h00; // space and anything unknown: blank
        endcase
    endfunction

    task automatic predict_item(input logic [1:0] op, input logic [1:0] pos,
                                input logic [7:0] ch, input logic [2:0] bi,
                                input logic bon);
        logic [15:0] period;
        logic [3:0]  enables;
        t_frame      f;
        case (op)
            OP_WRITE_CHAR: text_q[pos] = ch;
            OP_SET_BIT:    mask_q[bi] = bon;
            OP_TICK: begin
                if (countdown_q != 16'd0) begin
                    countdown_q = countdown_q - 16'd1;
                end else begin
                    period      = (period_q == 16'd0) ? 16'd1 : period_q;
                    countdown_q = period - 16'd1;
                    digit_q     = digit_q + 2'd1;
                    f.seg_byte  = char_to_segments(text_q[digit_q]);
                    if (seg_low_q) f.seg_byte = ~f.seg_byte;
                    enables = 4'b0001 << digit_q;
                    if (dig_low_q) enables = ~enables;
                    f.digit_byte = {mask_q[7:4], enables};
                    frames_due.push_back(f);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIGITS; k++) text_q[k] = CHAR_DASH;
            mask_q      = 8'h00;
            digit_q     = 2'd0;
            countdown_q = 16'd0;
            period_q    = MUX_PERIOD_RST;
            seg_low_q   = 1'b0;
            dig_low_q   = 1'b0;
            frames_due.delete();
        end else begin
            // a frame can never leave on the edge its tick is taken
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    report_mismatch($sformatf("frame %h/%h with none due",
                                              i_digit_byte, i_seg_byte));
                end else begin
                    want = frames_due.pop_front();
                    if (i_digit_byte !== want.digit_byte)
                        report_mismatch($sformatf("digit_byte %h, want %h",
                                                  i_digit_byte, want.digit_byte));
                    if (i_seg_byte !== want.seg_byte)
                        report_mismatch($sformatf("seg_byte %h, want %h",
                                                  i_seg_byte, want.seg_byte));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_opcode, i_position, i_char_code, i_bit_index, i_bit_on);
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_MUX_PERIOD:  period_q  = i_pwdata[15:0];
                        REG_SEG_ACT_LOW: seg_low_q = i_pwdata[0];
                        REG_DIG_ACT_LOW: dig_low_q = i_pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[3:2])
                        REG_MUX_PERIOD:  reg_val = {16'd0, i_prdata[15:0] ^ period_q};
                        REG_SEG_ACT_LOW: reg_val = {31'd0, i_prdata[0] ^ seg_low_q};
                        REG_DIG_ACT_LOW: reg_val = {31'd0, i_prdata[0] ^ dig_low_q};
                        default:         reg_val = 32'd0;
                    endcase
                    if (reg_val !== 32'd0)
                        report_mismatch($sformatf("read of %h gave %h", i_paddr, i_prdata));
                end
            end
        end
        o_outstanding <= frames_due.size();
    end

endmodule

/* dv/seven_segment_mux_driver_tb.sv */
`timescale 1ns / 100ps
module seven_segment_mux_driver_tb;
    import ssmd_pkg::*;

    // opcode 3 has no meaning; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 26;   // rough share of idle cycles per side
    localparam int HOLD_CYCLES = 64;   // long receiver stall for the back-pressure phase
    localparam int SETTLE      = 4;    // slack after the last due frame has left
    localparam int PHASE_ITEMS = 138;
    localparam int LONG_TICKS  = 16;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_opcode    = 2'd0;
    logic [1:0]  i_position  = 2'd0;
    logic [7:0]  i_char_code = 8'd0;
    logic [2:0]  i_bit_index = 3'd0;
    logic        i_bit_on    = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'd0;
    logic [31:0] pwdata      = 32'd0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire  [7:0]  o_digit_byte;
    wire  [7:0]  o_seg_byte;
    wire  [31:0] prdata;
    wire         pready;

    int errors;
    int frames_pending;

    // both sides idle at random while this is set
    bit gaps_on      = 1'b1;
    // asks the receiver process for one long counted stall
    bit hold_request = 1'b0;

    // characters with a glyph, so random text is mostly visible
    string shown_chars = "0123456789-_ AabCcdEeFfHhIiLlNnOoPpUu*";

    seven_segment_mux_driver i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_char_code  (i_char_code),
        .i_bit_index  (i_bit_index),
        .i_bit_on     (i_bit_on),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_digit_byte (o_digit_byte),
        .o_seg_byte   (o_seg_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    seven_segment_mux_driver_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_char_code   (i_char_code),
        .i_bit_index   (i_bit_index),
        .i_bit_on      (i_bit_on),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_digit_byte  (o_digit_byte),
        .i_seg_byte    (o_seg_byte),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_outstanding (frames_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one item and hold it until taken. Valid is only dropped when a
    // gap is inserted, so back-to-back items never lower and raise it in
    // the same step.
    task automatic send_item(input logic [1:0] op, input logic [1:0] pos,
                             input logic [7:0] ch, input logic [2:0] bi,
                             input logic bon);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_position  <= pos;
        i_char_code <= ch;
        i_bit_index <= bi;
        i_bit_on    <= bon;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every due frame, then let the pipe settle:
    // a tick that only counts down leaves nothing to wait for.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // setup then access; a spare cycle after so the next transfer never
    // lowers and raises psel in the same step
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all three registers while idle and read them back; the
    // checker picks up both the writes and the read data.
    task automatic configure(input logic [15:0] period, input logic seg_low,
                             input logic dig_low);
        drain();
        apb_access(1'b1, REG_MUX_PERIOD,  {16'd0, period});
        apb_access(1'b1, REG_SEG_ACT_LOW, {31'd0, seg_low});
        apb_access(1'b1, REG_DIG_ACT_LOW, {31'd0, dig_low});
        apb_access(1'b0, REG_MUX_PERIOD,  32'd0);
        apb_access(1'b0, REG_SEG_ACT_LOW, 32'd0);
        apb_access(1'b0, REG_DIG_ACT_LOW, 32'd0);
    endtask

    // Mostly ticks and character writes, some mask changes, a little of the
    // unused opcode. Every field is random on every item, used or not.
    task automatic run_random(input int count);
        int         pick;
        logic [1:0] op;
        logic [7:0] ch;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 55)      op = OP_TICK;
            else if (pick < 85) op = OP_WRITE_CHAR;
            else if (pick < 97) op = OP_SET_BIT;
            else                op = OP_UNUSED;
            if ($urandom_range(1) == 1)
                ch = shown_chars[$urandom_range(shown_chars.len() - 1)];
            else
                ch = 8'($urandom);
            send_item(op, 2'($urandom), ch, 3'($urandom), 1'($urandom));
        end
    endtask

    // Receiver: random ready, except for one long stall on request which is
    // counted here while the sender keeps offering.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers
        apb_access(1'b0, REG_MUX_PERIOD,  32'd0);
        apb_access(1'b0, REG_SEG_ACT_LOW, 32'd0);
        apb_access(1'b0, REG_DIG_ACT_LOW, 32'd0);

        // --- directed ---
        // fill the text store but leave position 1 at its reset dash;
        // extreme codes have no glyph and show blank
        send_item(OP_WRITE_CHAR, 2'd0, "8",   3'd0, 1'b0);
        send_item(OP_WRITE_CHAR, 2'd2, 8'hFF, 3'd7, 1'b1);
        send_item(OP_WRITE_CHAR, 2'd3, 8'h00, 3'd0, 1'b0);
        // extra bits: high nibble reaches the digit byte, low bits never do
        send_item(OP_SET_BIT,    2'd3, 8'hFF, 3'd7, 1'b1);
        send_item(OP_SET_BIT,    2'd0, 8'h00, 3'd4, 1'b1);
        send_item(OP_SET_BIT,    2'd0, 8'h00, 3'd0, 1'b1);
        send_item(OP_SET_BIT,    2'd0, 8'h00, 3'd3, 1'b1);
        // unused opcode with every field at its top: nothing changes
        send_item(OP_UNUSED,     2'd3, 8'hFF, 3'd7, 1'b1);

        // shortest period, both polarities active high: every tick lights
        // the next digit, starting from digit 1
        configure(16'd1, 1'b0, 1'b0);
        repeat (4) send_item(OP_TICK, 2'd0, 8'h00, 3'd0, 1'b0);
        send_item(OP_SET_BIT,    2'd1, 8'h00, 3'd7, 1'b0);
        send_item(OP_WRITE_CHAR, 2'd1, "*",   3'd0, 1'b0);

        // zero period behaves as one; both outputs inverted
        configure(16'd0, 1'b1, 1'b1);
        repeat (4) send_item(OP_TICK, 2'd3, 8'hFF, 3'd7, 1'b1);
        send_item(OP_SET_BIT,    2'd0, 8'h00, 3'd6, 1'b1);
        send_item(OP_WRITE_CHAR, 2'd2, "a",   3'd0, 1'b0);
        repeat (2) send_item(OP_TICK, 2'd0, 8'h00, 3'd0, 1'b0);

        // --- random phases over varied settings; one phase without gaps ---
        for (int ph = 0; ph < 8; ph++) begin
            logic [15:0] per;
            case ($urandom_range(3))
                0:       per = 16'd1;
                1:       per = 16'($urandom_range(2, 6));
                2:       per = 16'd0;
                default: per = 16'($urandom_range(7, 30));
            endcase
            configure(per, 1'($urandom), 1'($urandom));
            gaps_on = (ph != 3);
            run_random(PHASE_ITEMS);
        end
        gaps_on = 1'b1;

        // back-pressure: a frame per tick while the receiver stalls, so the
        // output buffer fills and the input has to stop taking items
        configure(16'd1, 1'b0, 1'b1);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_item(OP_TICK, 2'($urandom), 8'($urandom), 3'($urandom),
                              1'($urandom));
        gaps_on = 1'b1;

        // longest period: the first tick refreshes and reloads from the top
        // value, the rest only count down
        configure(16'hFFFF, 1'($urandom), 1'($urandom));
        for (int k = 0; k < LONG_TICKS; k++)
            send_item(OP_TICK, 2'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
